/* src/u8v_pkg.sv */
`default_nettype none

package u8v_pkg;

   // widths of the item fields
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned PEND_W = 2;

   // forbidden code point ranges in comment mode
   localparam logic [CP_W-1:0] CP_TAB        = 21'h00_0009;
   localparam logic [CP_W-1:0] CP_C0_LAST    = 21'h00_001F;
   localparam logic [CP_W-1:0] CP_DEL        = 21'h00_007F;
   localparam logic [CP_W-1:0] CP_C1_LAST    = 21'h00_009F;
   localparam logic [CP_W-1:0] CP_LINE_SEP   = 21'h00_2028;
   localparam logic [CP_W-1:0] CP_PARA_SEP   = 21'h00_2029;

   // first error code reported with each item
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_CONT  = 2'd1,
      ERR_BAD_LEAD  = 2'd2,
      ERR_FORBIDDEN = 2'd3
   } err_type;

   // decoder state carried from byte to byte
   typedef struct packed {
      logic [PEND_W-1:0] pending;
      logic [CP_W-1:0]   acc;
      logic              err_seen;
      err_type           err_code;
   } dec_state_type;

   // result fields of one item
   typedef struct packed {
      logic            still_valid;
      err_type         error_kind;
      logic [CP_W-1:0] code_point;
      logic            code_point_done;
      logic            end_of_string;
      logic            incomplete;
   } dec_result_type;

endpackage

`default_nettype wire

/* src/u8v_forbid.sv */
`default_nettype none

module u8v_forbid
   import u8v_pkg::*;
(
   input  wire logic [CP_W-1:0] cp,
   output logic                 forbidden
);

   // c0 controls except tab, del and c1 controls, line and paragraph separators
   always_comb begin
      forbidden = ((cp <= CP_C0_LAST) && (cp != CP_TAB))
               || ((cp >= CP_DEL) && (cp <= CP_C1_LAST))
               || (cp == CP_LINE_SEP)
               || (cp == CP_PARA_SEP);
   end

endmodule

`default_nettype wire

/* src/u8v_step.sv */
`default_nettype none

module u8v_step
   import u8v_pkg::*;
(
   input  wire dec_state_type      state,
   input  wire logic [BYTE_W-1:0]  byte_value,
   input  wire logic               op,
   input  wire logic               last_byte,
   output dec_state_type           state_next,
   output dec_result_type          result
);

   logic [PEND_W-1:0] pend_upd;
   logic [CP_W-1:0]   acc_upd;
   err_type           struct_err;
   err_type           err;
   logic              forbidden;
   logic              done;
   logic              incomplete;
   dec_state_type     upd;

   // structural decode: lead and continuation bytes
   always_comb begin
      pend_upd   = state.pending;
      acc_upd    = state.acc;
      struct_err = ERR_NONE;
      if (state.pending != '0) begin
         if (byte_value[7:6] != 2'b10) begin
            struct_err = ERR_BAD_CONT;
         end else begin
            pend_upd = state.pending - PEND_W'(1);
            acc_upd  = {state.acc[CP_W-7:0], byte_value[5:0]};
         end
      end else if (!byte_value[7]) begin
         acc_upd = CP_W'(byte_value);
      end else if (byte_value[7:5] == 3'b110) begin
         pend_upd = PEND_W'(1);
         acc_upd  = CP_W'(byte_value[4:0]);
      end else if (byte_value[7:4] == 4'b1110) begin
         pend_upd = PEND_W'(2);
         acc_upd  = CP_W'(byte_value[3:0]);
      end else if (byte_value[7:3] == 5'b11110) begin
         pend_upd = PEND_W'(3);
         acc_upd  = CP_W'(byte_value[2:0]);
      end else begin
         struct_err = ERR_BAD_LEAD;
      end
   end

   u8v_forbid u_forbid (
      .cp        (acc_upd),
      .forbidden (forbidden)
   );

   // error merge, sticky first error and end of string handling
   always_comb begin
      upd        = state;
      err        = ERR_NONE;
      done       = 1'b0;
      incomplete = 1'b0;
      if (!state.err_seen) begin
         upd.pending = pend_upd;
         upd.acc     = acc_upd;
         err         = struct_err;
         if ((struct_err == ERR_NONE) && (pend_upd == '0)) begin
            done = 1'b1;
            if (op && forbidden) begin
               err = ERR_FORBIDDEN;
            end
         end
         if (err != ERR_NONE) begin
            upd.err_seen = 1'b1;
            upd.err_code = err;
         end
         incomplete = last_byte && !upd.err_seen && (upd.pending != '0);
      end

      result.still_valid     = !upd.err_seen;
      result.error_kind      = upd.err_code;
      result.code_point      = upd.acc;
      result.code_point_done = done;
      result.end_of_string   = last_byte;
      result.incomplete      = incomplete;

      // the final byte of a string returns the decoder to its reset state
      if (last_byte) begin
         state_next = '0;
      end else begin
         state_next = upd;
      end
   end

endmodule

`default_nettype wire

/* src/utf8_stream_validator.sv */
// UTF-8 stream validator: takes one byte of a string per item and returns one
// result per byte (still valid, first error code, code point so far, code
// point completed, end of string echo, unfinished sequence at the end). It
// sustains one byte per cycle when the output is not stalled; each byte passes
// through an input register and then a single pass of decode logic into the
// result register, where the result is held until it is taken.
// The decoder state (pending continuations, accumulator, sticky first error)
// is updated in that same pass, and it returns to reset after the byte marked
// last. In comment mode each completed code point is checked against C0
// controls other than tab, 0x7F to 0x9F, U+2028 and U+2029. Overlong forms,
// surrogates and values above U+10FFFF are not rejected.
`default_nettype none

module utf8_stream_validator
   import u8v_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [BYTE_W-1:0]  req_byte_value,
   input  wire logic               req_op,
   input  wire logic               req_last_byte,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_still_valid,
   output logic [1:0]              rsp_error_kind,
   output logic [CP_W-1:0]         rsp_code_point,
   output logic                    rsp_code_point_done,
   output logic                    rsp_end_of_string,
   output logic                    rsp_incomplete
);

   logic                s1_valid_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic                s1_op_ff;
   logic                s1_last_ff;
   dec_state_type       state_ff;
   dec_state_type       state_in;
   dec_result_type      result_in;
   dec_result_type      rsp_ff;
   logic                rsp_valid_ff;
   logic                advance;

   // handshake: the result register frees up when empty or taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_byte_value;
         s1_op_ff   <= req_op;
         s1_last_ff <= req_last_byte;
      end
   end

   u8v_step u_step (
      .state      (state_ff),
      .byte_value (s1_byte_ff),
      .op         (s1_op_ff),
      .last_byte  (s1_last_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // decoder state, updated as each item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_still_valid     = rsp_ff.still_valid;
   assign rsp_error_kind      = rsp_ff.error_kind;
   assign rsp_code_point      = rsp_ff.code_point;
   assign rsp_code_point_done = rsp_ff.code_point_done;
   assign rsp_end_of_string   = rsp_ff.end_of_string;
   assign rsp_incomplete      = rsp_ff.incomplete;

   // still valid exactly when no error code is reported
   a_valid_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_still_valid == (rsp_error_kind == ERR_NONE)))
      else $error("still_valid disagrees with error_kind");

   // an unfinished sequence is only flagged on a clean final byte
   a_incomplete_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_incomplete)
         |-> (rsp_end_of_string && rsp_still_valid && !rsp_code_point_done))
      else $error("incomplete flagged on a wrong item");

   // decoder state is cleared after the final byte of a string
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff)
         |=> ((state_ff.pending == '0) && !state_ff.err_seen && (state_ff.acc == '0)))
      else $error("decoder state not cleared at end of string");

   // a result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
